// ===== rtl/dhm_pkg.sv =====
// Shared constants and types for the Diffie-Hellman modular exponentiation engine.
`timescale 1ns / 1ps

package dhm_pkg;

    // Width of the modulus and operands actually used; port fields stay FIELD_W wide.
    localparam int KEY_BITS = 64;
    localparam int FIELD_W  = 64;
    localparam int CNT_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [KEY_BITS-1:0] MIN_MODULUS = KEY_BITS'(5);
    localparam logic [KEY_BITS-1:0] KEY_ONE     = KEY_BITS'(1);
    localparam logic [CNT_W-1:0]    CNT_LAST    = CNT_W'(KEY_BITS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_PEER   = 2'd1;
    localparam logic [1:0] STATUS_BAD_PARAMS = 2'd2;

    // Status of a modular multiplier toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

// ===== rtl/dhm_mulmod.sv =====
// Bit-serial modular multiplier: multiplier bits are taken MSB first, each in a double phase and an add phase.
`timescale 1ns / 1ps

module dhm_mulmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dhm_pkg::KEY_BITS-1:0]  a,
    input  logic [dhm_pkg::KEY_BITS-1:0]  b,
    input  logic [dhm_pkg::KEY_BITS-1:0]  m,
    output dhm_pkg::mul_status_t          stat,
    output logic [dhm_pkg::KEY_BITS-1:0]  product
);
    import dhm_pkg::*;

    logic [KEY_BITS-1:0] acc_reg, acc_next;
    logic [KEY_BITS-1:0] a_reg;
    logic [KEY_BITS-1:0] b_sh_reg, b_sh_next;
    logic [KEY_BITS-1:0] m_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                phase_reg, phase_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [KEY_BITS-1:0] addend;
    logic [KEY_BITS:0]   sum;
    logic [KEY_BITS:0]   reduced;

    // Phase 0 doubles the accumulator, phase 1 adds a when the current bit of b is set.
    // Both operands are below m, so one conditional subtract keeps the sum reduced.
    assign addend  = phase_reg ? a_reg : acc_reg;
    assign sum     = {1'b0, acc_reg} + {1'b0, addend};
    assign reduced = (sum >= {1'b0, m_reg}) ? (sum - {1'b0, m_reg}) : sum;

    always_comb
    begin
        acc_next   = acc_reg;
        b_sh_next  = b_sh_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            acc_next   = '0;
            b_sh_next  = b;
            cnt_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                acc_next   = reduced[KEY_BITS-1:0];
                phase_next = 1'b1;
            end
            else
            begin
                if (b_sh_reg[KEY_BITS-1])
                begin
                    acc_next = reduced[KEY_BITS-1:0];
                end
                b_sh_next  = b_sh_reg << 1;
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        b_sh_reg <= b_sh_next;
        if (start)
        begin
            a_reg <= a;
            m_reg <= m;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// ===== rtl/diffie_hellman_modexp.sv =====
// Top level of the Diffie-Hellman modular exponentiation engine.
`timescale 1ns / 1ps

// A request computes generator^x mod p (kind 0) or peer_value^x mod p (kind 1), with x the
// private exponent register. Exponentiation is square-and-multiply over the exponent bits,
// least significant first; each round runs the square and the conditional multiply side by
// side on two bit-serial modular multipliers. Requests rejected for bad parameters or a bad
// peer value skip the multipliers and finish with a zero key. Configuration must be written
// only while the engine is idle; the block itself does not enforce this. A new request is
// taken while the previous result waits on the output.
module diffie_hellman_modexp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dhm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dhm_pkg::FIELD_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [dhm_pkg::FIELD_W-1:0]       peer_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dhm_pkg::FIELD_W-1:0]       key_value,
    output logic [1:0]                        status
);
    import dhm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_BITS-1:0] modulus_reg, generator_reg, exponent_reg;
    logic [KEY_BITS-1:0] m_reg, m_next;
    logic [KEY_BITS-1:0] r_reg, r_next;
    logic [KEY_BITS-1:0] bb_reg, bb_next;
    logic [KEY_BITS-1:0] e_sh_reg, e_sh_next;
    logic [CNT_W-1:0]    round_reg, round_next;
    logic [1:0]          st_reg, st_next;

    logic                out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0] key_out_reg, key_out_next;
    logic [1:0]          status_out_reg, status_out_next;

    logic                in_xfer;
    logic                out_free;
    logic                mul_start;
    logic [KEY_BITS-1:0] peer_k;
    logic                bad_params;
    logic                bad_peer;
    logic [1:0]          req_status;

    mul_status_t         mul_r_stat, mul_b_stat;
    logic [KEY_BITS-1:0] mul_r_product, mul_b_product;

    // Configuration registers keep only the bits the arithmetic uses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= '0;
            generator_reg <= '0;
            exponent_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS:   modulus_reg   <= cfg_data[KEY_BITS-1:0];
                CFG_GENERATOR: generator_reg <= cfg_data[KEY_BITS-1:0];
                CFG_EXPONENT:  exponent_reg  <= cfg_data[KEY_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign peer_k     = peer_value[KEY_BITS-1:0];
    assign bad_params = (modulus_reg < MIN_MODULUS) || (generator_reg <= KEY_ONE)
                        || (generator_reg >= modulus_reg);
    assign bad_peer   = kind && ((peer_k <= KEY_ONE) || (peer_k >= modulus_reg));
    assign req_status = bad_params ? STATUS_BAD_PARAMS
                      : (bad_peer ? STATUS_BAD_PEER : STATUS_OK);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign mul_start = (state_reg == S_START);

    dhm_mulmod u_mul_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (r_reg),
        .b       (bb_reg),
        .m       (m_reg),
        .stat    (mul_r_stat),
        .product (mul_r_product)
    );

    dhm_mulmod u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (bb_reg),
        .b       (bb_reg),
        .m       (m_reg),
        .stat    (mul_b_stat),
        .product (mul_b_product)
    );

    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        r_next          = r_reg;
        bb_next         = bb_reg;
        e_sh_next       = e_sh_reg;
        round_next      = round_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        key_out_next    = key_out_reg;
        status_out_next = status_out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    m_next     = modulus_reg;
                    r_next     = (req_status == STATUS_OK) ? KEY_ONE : '0;
                    bb_next    = kind ? peer_k : generator_reg;
                    e_sh_next  = exponent_reg;
                    round_next = '0;
                    st_next    = req_status;
                    state_next = (req_status == STATUS_OK) ? S_START : S_FINISH;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_r_stat.done)
                begin
                    if (e_sh_reg[0])
                    begin
                        r_next = mul_r_product;
                    end
                    bb_next    = mul_b_product;
                    e_sh_next  = e_sh_reg >> 1;
                    round_next = round_reg + 1'b1;
                    state_next = (round_reg == CNT_LAST) ? S_FINISH : S_START;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    key_out_next    = r_reg;
                    status_out_next = st_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        r_reg          <= r_next;
        bb_reg         <= bb_next;
        e_sh_reg       <= e_sh_next;
        st_reg         <= st_next;
        key_out_reg    <= key_out_next;
        status_out_reg <= status_out_next;
    end

    assign out_valid = out_valid_reg;
    assign key_value = FIELD_W'(key_out_reg);
    assign status    = status_out_reg;

    // The two multipliers are started together and must finish together.
    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_r_stat.done == mul_b_stat.done) && (mul_r_stat.busy == mul_b_stat.busy))
        else $error("multipliers out of step");

    // A multiplier result only arrives while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_r_stat.done |-> (state_reg == S_WAIT))
        else $error("multiplier result outside wait state");

    // A rejected request carries a zero key.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (key_value == '0))
        else $error("nonzero key with error status");

    // A good key is fully reduced modulo p.
    a_key_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_OK)) |-> (key_out_reg < modulus_reg))
        else $error("key not reduced");

endmodule
